// ===== hdl/hsr_pkg.sv =====
// Shared types and constants for the Heron square root block.
// No dependencies; heron_square_root refers to this package by scoped names.
`default_nettype none

package hsr_pkg;

    // Fixed field widths of the ports
    localparam int ROOT_W   = 32;
    localparam int TOL_W    = 32;
    localparam int ITER_W   = 6;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NEG = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CAP = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 1'd1;

    // Reset values of the configuration registers
    localparam logic [TOL_W-1:0]  TOL_RESET  = 32'd65536;
    localparam logic [ITER_W-1:0] ITER_RESET = 6'd32;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SQUARE,
        S_TEST,
        S_DIVIDE,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/hsr_mul.sv =====
// Bit-serial shift-add squarer/multiplier: one multiplier bit per cycle.
// Used by heron_square_root; no package dependencies.
`default_nettype none

module hsr_mul #(
    parameter int W = 47
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [W-1:0]   i_a,
    input  wire logic [W-1:0]   i_b,
    output logic                o_done,
    output logic [2*W-1:0]      o_product
);

    localparam int CNT_W = $clog2(W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_a;
    logic [W-1:0]     r_acc;
    logic [W-1:0]     r_mq;
    logic [W-1:0]     n_acc;
    logic [W-1:0]     n_mq;
    logic [W:0]       w_sum;

    // Add the multiplicand under the low multiplier bit, shift the pair right
    always_comb begin
        w_sum = {1'b0, r_acc} + (r_mq[0] ? {1'b0, r_a} : {(W+1){1'b0}});
        n_acc = w_sum[W:1];
        n_mq  = {w_sum[0], r_mq[W-1:1]};
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial product shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_acc <= '0;
            r_mq  <= i_b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_mq  <= n_mq;
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_acc, r_mq};

endmodule

`default_nettype wire

// ===== hdl/hsr_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Used by heron_square_root; no package dependencies.
`default_nettype none

module hsr_div #(
    parameter int W = 47
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_rem,   // upper dividend part, below the divisor
    input  wire logic [W-1:0] i_num,   // lower dividend part
    input  wire logic [W-1:0] i_den,
    output logic              o_done,
    output logic [W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_den;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_nq;
    logic [W-1:0]     n_rem;
    logic [W-1:0]     n_nq;
    logic [W:0]       w_sh;
    logic [W+1:0]     w_sub;

    // Bring down the next dividend bit, subtract the divisor if it fits
    always_comb begin
        w_sh  = {r_rem, r_nq[W-1]};
        w_sub = {1'b0, w_sh} - {2'b00, r_den};
        if (!w_sub[W+1]) begin
            n_rem = w_sub[W-1:0];
            n_nq  = {r_nq[W-2:0], 1'b1};
        end else begin
            n_rem = w_sh[W-1:0];
            n_nq  = {r_nq[W-2:0], 1'b0};
        end
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and dividend/quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= i_rem;
            r_nq  <= i_num;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_nq  <= n_nq;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_nq;

endmodule

`default_nettype wire

// ===== hdl/heron_square_root.sv =====
// Heron square root top level: sequencer, error test and output register.
// Depends on hsr_pkg, hsr_mul and hsr_div.
//
// Takes a signed integer word and returns its square root in unsigned fixed point
// with FRAC_BITS fraction bits (Q16.16 by default), the number of Heron steps and a
// status (converged, negative input, iteration cap). The estimate starts at x/2 and
// is refined by r = (r + x/r)/2 until |r*r - x| is within the tolerance register
// (units of 2^-32) or the max_iterations register is reached. One item is worked on
// at a time. Negative and zero inputs go straight to the finish state. Otherwise the
// estimate is RW = INPUT_BITS + FRAC_BITS - 1 bits wide (47 by default), and the
// squarer and the divider both produce one bit per cycle. A finished word waits in
// the output register, so the next input can be taken before it is collected.
`default_nettype none

module heron_square_root #(
    parameter int INPUT_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [hsr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [hsr_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic signed [INPUT_BITS-1:0]       i_value,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [hsr_pkg::ROOT_W-1:0]              o_root,
    output logic [hsr_pkg::ITER_W-1:0]              o_iterations,
    output logic [hsr_pkg::STATUS_W-1:0]            o_status
);

    localparam int RW = INPUT_BITS + FRAC_BITS - 1;      // estimate width
    localparam int XW = INPUT_BITS - 1 + 2 * FRAC_BITS;  // x * 2^2F width
    localparam int PW = 2 * RW;                          // square width
    localparam int CW = PW + hsr_pkg::TOL_W;             // tolerance compare width
    localparam int SA = (2 * FRAC_BITS < 32) ? 32 - 2 * FRAC_BITS : 0;
    localparam int SB = (2 * FRAC_BITS > 32) ? 2 * FRAC_BITS - 32 : 0;
    localparam int RTW = hsr_pkg::ROOT_W;

    hsr_pkg::t_state r_state;
    hsr_pkg::t_state n_state;

    logic [hsr_pkg::TOL_W-1:0]    r_tol;
    logic [hsr_pkg::ITER_W-1:0]   r_max_it;
    logic [XW-1:0]                r_x2;
    logic [RW-1:0]                r_est;
    logic [hsr_pkg::ITER_W-1:0]   r_it;
    logic [hsr_pkg::STATUS_W-1:0] r_status;
    logic [PW-1:0]                r_err;

    logic                         r_out_valid;
    logic [RTW-1:0]               r_root;
    logic [hsr_pkg::ITER_W-1:0]   r_out_it;
    logic [hsr_pkg::STATUS_W-1:0] r_out_status;

    logic          w_in_accept;
    logic          w_mul_start;
    logic          w_div_start;
    logic          w_out_load;
    logic          w_mul_done;
    logic          w_div_done;
    logic [PW-1:0] w_prod;
    logic [RW-1:0] w_quot;
    logic [PW-1:0] w_x2_ext;
    logic [PW:0]   w_d1;
    logic [PW-1:0] w_d2;
    logic [CW-1:0] w_lhs;
    logic [CW-1:0] w_rhs;
    logic          w_far;
    logic          w_cap;
    logic [RW:0]   w_sum;
    logic [RW+RTW-1:0] w_est_ext;
    logic          w_wide;

    // Serial squarer of the estimate
    hsr_mul #(.W(RW)) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (r_est),
        .i_b       (r_est),
        .o_done    (w_mul_done),
        .o_product (w_prod)
    );

    // Serial divider for x * 2^2F / r; the quotient always fits RW bits
    hsr_div #(.W(RW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_rem   ({{(RW-FRAC_BITS){1'b0}}, r_x2[XW-1:RW]}),
        .i_num   (r_x2[RW-1:0]),
        .i_den   (r_est),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Error, tolerance test and update arithmetic
    always_comb begin
        w_x2_ext  = {{(PW-XW){1'b0}}, r_x2};
        w_d1      = {1'b0, w_prod} - {1'b0, w_x2_ext};
        w_d2      = w_x2_ext - w_prod;
        w_lhs     = {{hsr_pkg::TOL_W{1'b0}}, r_err} << SA;
        w_rhs     = {{PW{1'b0}}, r_tol} << SB;
        w_far     = w_lhs > w_rhs;
        w_cap     = r_it >= r_max_it;
        w_sum     = {1'b0, r_est} + {1'b0, w_quot};
        w_est_ext = {{RTW{1'b0}}, r_est};
        w_wide    = w_est_ext[RW+RTW-1:RTW] != '0;
    end

    // Next state and strobes
    always_comb begin
        n_state     = r_state;
        o_ready     = 1'b0;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            hsr_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_value[INPUT_BITS-1] || i_value == '0) begin
                        n_state = hsr_pkg::S_FINISH;
                    end else begin
                        n_state = hsr_pkg::S_START;
                    end
                end
            end
            hsr_pkg::S_START: begin
                w_mul_start = 1'b1;
                n_state     = hsr_pkg::S_SQUARE;
            end
            hsr_pkg::S_SQUARE: begin
                if (w_mul_done) begin
                    n_state = hsr_pkg::S_TEST;
                end
            end
            hsr_pkg::S_TEST: begin
                if (!w_far || w_cap) begin
                    n_state = hsr_pkg::S_FINISH;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = hsr_pkg::S_DIVIDE;
                end
            end
            hsr_pkg::S_DIVIDE: begin
                if (w_div_done) begin
                    n_state = hsr_pkg::S_START;
                end
            end
            hsr_pkg::S_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    w_out_load = 1'b1;
                    n_state    = hsr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hsr_pkg::S_IDLE;
            end
        endcase
    end

    assign w_in_accept = i_valid && o_ready;

    // State and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hsr_pkg::S_IDLE;
            r_tol    <= hsr_pkg::TOL_RESET;
            r_max_it <= hsr_pkg::ITER_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    hsr_pkg::CFG_TOLERANCE: r_tol    <= i_cfg_data;
                    hsr_pkg::CFG_MAX_ITER:  r_max_it <= i_cfg_data[hsr_pkg::ITER_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Working registers: operand, estimate, step count, error, status
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_x2     <= {i_value[INPUT_BITS-2:0], {(2*FRAC_BITS){1'b0}}};
            r_est    <= {1'b0, i_value[INPUT_BITS-2:0], {(FRAC_BITS-1){1'b0}}};
            r_it     <= '0;
            r_status <= i_value[INPUT_BITS-1] ? hsr_pkg::STATUS_NEG : hsr_pkg::STATUS_OK;
            if (i_value[INPUT_BITS-1]) begin
                r_est <= '0;
            end
        end
        if (r_state == hsr_pkg::S_SQUARE && w_mul_done) begin
            r_err <= w_d1[PW] ? w_d2 : w_d1[PW-1:0];
        end
        if (r_state == hsr_pkg::S_TEST && w_far && w_cap) begin
            r_status <= hsr_pkg::STATUS_CAP;
        end
        if (r_state == hsr_pkg::S_DIVIDE && w_div_done) begin
            r_est <= w_sum[RW:1];
            r_it  <= r_it + hsr_pkg::ITER_W'(1);
        end
    end

    // Output register: hold the word until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_root       <= w_wide ? {RTW{1'b1}} : w_est_ext[RTW-1:0];
            r_out_it     <= r_it;
            r_out_status <= r_status;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_root       = r_root;
    assign o_iterations = r_out_it;
    assign o_status     = r_out_status;

`ifndef SYNTHESIS
    a_neg_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == hsr_pkg::STATUS_NEG |-> o_root == '0 && o_iterations == '0)
        else $error("negative input word carries a nonzero root or step count");

    a_accept_leaves_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> r_state != hsr_pkg::S_IDLE)
        else $error("accepted word did not start the sequencer");

    a_mul_done_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> r_state == hsr_pkg::S_SQUARE)
        else $error("squarer finished outside the square state");

    a_div_done_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == hsr_pkg::S_DIVIDE)
        else $error("divider finished outside the divide state");

    a_out_from_finish : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == hsr_pkg::S_FINISH)
        else $error("output word appeared without a finished item");
`endif

endmodule

`default_nettype wire

// ===== test/heron_square_root_test.sv =====
// Self-checking testbench for heron_square_root: random and corner values, several
// tolerance and iteration cap settings, random stalls on both handshakes.
// Depends on hsr_pkg and the heron_square_root RTL.
`timescale 1ns / 1ps

module heron_square_root_test;

    localparam int unsigned LIMIT_CYCLES = 30_000_000;
    localparam int unsigned HOLD_CYCLES  = 2000;
    localparam int unsigned TAIL_CYCLES  = 200;
    localparam int unsigned NUM_PHASES   = 9;

    typedef struct packed {
        logic [hsr_pkg::ROOT_W-1:0]   root;
        logic [hsr_pkg::ITER_W-1:0]   iterations;
        logic [hsr_pkg::STATUS_W-1:0] status;
    } root_word_t;

    // Predict each result word and hold it until the block delivers it
    class root_scoreboard;
        logic [hsr_pkg::TOL_W-1:0]  tolerance_reg;
        logic [hsr_pkg::ITER_W-1:0] cap_reg;
        root_word_t                 pending_roots[$];
        int unsigned                errors;

        function new();
            tolerance_reg = hsr_pkg::TOL_RESET;
            cap_reg       = hsr_pkg::ITER_RESET;
            errors        = 0;
        endfunction

        function void set_reg(logic [hsr_pkg::CFG_IDX_W-1:0] index,
                              logic [hsr_pkg::CFG_W-1:0] data);
            case (index)
                hsr_pkg::CFG_TOLERANCE: tolerance_reg = data;
                hsr_pkg::CFG_MAX_ITER:  cap_reg = data[hsr_pkg::ITER_W-1:0];
                default: ;
            endcase
        endfunction

        // Heron iteration in exact 192-bit fixed point, Q.16 estimate
        function root_word_t solve_root(logic [31:0] value);
            logic [191:0] target, est, quot, sq, err, lim;
            root_word_t   word;
            int unsigned  steps;
            word  = '0;
            steps = 0;
            if (value[31]) begin
                word.status = hsr_pkg::STATUS_NEG;
                return word;
            end
            word.status = hsr_pkg::STATUS_OK;
            if (value == 32'd0) begin
                return word;
            end
            target = {160'd0, value} << 32;
            est    = ({160'd0, value} << 16) >> 1;
            lim    = {160'd0, tolerance_reg} << 32;
            while (1'b1) begin
                sq  = est * est;
                err = (sq >= target) ? sq - target : target - sq;
                err = err << 32;
                if (err <= lim) break;
                if (steps >= cap_reg) begin
                    word.status = hsr_pkg::STATUS_CAP;
                    break;
                end
                quot = (est == 192'd0) ? '1 : target / est;
                est  = (est + quot) >> 1;
                steps++;
            end
            // Saturate an estimate too wide for the root field
            word.root       = (est[191:32] != 160'd0) ? '1 : est[31:0];
            word.iterations = steps[hsr_pkg::ITER_W-1:0];
            return word;
        endfunction

        function void note_value(logic [31:0] value);
            pending_roots.push_back(solve_root(value));
        endfunction

        function void check_root(root_word_t got);
            root_word_t want;
            if (pending_roots.size() == 0) begin
                $display("%0t unexpected word: root %h iterations %0d status %0d",
                         $time, got.root, got.iterations, got.status);
                errors++;
                return;
            end
            want = pending_roots.pop_front();
            if (got.root !== want.root) begin
                $display("%0t root mismatch: expected %h, got %h",
                         $time, want.root, got.root);
                errors++;
            end
            if (got.iterations !== want.iterations) begin
                $display("%0t iterations mismatch: expected %0d, got %0d",
                         $time, want.iterations, got.iterations);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t status mismatch: expected %0d, got %0d",
                         $time, want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [hsr_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [hsr_pkg::CFG_W-1:0]        i_cfg_data;
    logic                             i_valid;
    logic                             o_ready;
    logic signed [31:0]               i_value;
    logic                             o_valid;
    logic                             i_ready;
    logic [hsr_pkg::ROOT_W-1:0]       o_root;
    logic [hsr_pkg::ITER_W-1:0]       o_iterations;
    logic [hsr_pkg::STATUS_W-1:0]     o_status;

    root_scoreboard board;
    bit             stall_request;
    int unsigned    sender_calm;
    int unsigned    cycles;

    heron_square_root dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_root       (o_root),
        .o_iterations (o_iterations),
        .o_status     (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Random gap with occasional stretches of back-to-back words
    function automatic int unsigned draw_gap(inout int unsigned calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // Mix of negative, zero, perfect square, small and wide values
    function automatic logic [31:0] pick_value();
        int unsigned kind, k;
        kind = $urandom_range(0, 99);
        if (kind < 15) return $urandom | 32'h8000_0000;
        if (kind < 17) return 32'd0;
        if (kind < 35) begin
            k = $urandom_range(1, 46340);
            return k * k;
        end
        if (kind < 60) return $urandom_range(1, 4096);
        return $urandom >> $urandom_range(1, 31);
    endfunction

    // Offer one word and hold it until accepted; entered and left at a falling edge
    task automatic send_value(input logic [31:0] value, input bit eager);
        int unsigned gap;
        gap = eager ? 0 : draw_gap(sender_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Wait until every expected word has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (board.pending_roots.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write both registers while the block is idle
    task automatic set_config(input logic [31:0] tol, input logic [31:0] cap);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= hsr_pkg::CFG_TOLERANCE;
        i_cfg_data  <= tol;
        board.set_reg(hsr_pkg::CFG_TOLERANCE, tol);
        @(negedge i_clk);
        i_cfg_index <= hsr_pkg::CFG_MAX_ITER;
        i_cfg_data  <= cap;
        board.set_reg(hsr_pkg::CFG_MAX_ITER, cap);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin
        int unsigned gap, calm;
        calm    = 0;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (stall_request) begin
                stall_request = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = draw_gap(calm);
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    // Watch both handshakes and bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
        if (i_rst_n) begin
            if (i_valid && o_ready) board.note_value(i_value);
            if (o_valid && i_ready) board.check_root({o_root, o_iterations, o_status});
        end
    end

    // Stimulus
    initial begin
        logic [31:0] corner_values [15];
        logic [31:0] tol, cap;
        int unsigned count;
        corner_values = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd16, 32'd7,
                          32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                          32'h4000_0000, 32'd2147395600, 32'h5555_5555,
                          32'h2AAA_AAAA, 32'hAAAA_AAAA};
        board         = new();
        stall_request = 1'b0;
        sender_calm   = 0;
        cycles        = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = hsr_pkg::CFG_TOLERANCE;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_value       = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Corner values under the reset settings
        foreach (corner_values[i]) send_value(corner_values[i], 1'b0);

        // Widest tolerance with a single step: wide estimates saturate
        set_config(32'hFFFF_FFFF, 32'd1);
        send_value(32'h7FFF_FFFF, 1'b0);
        send_value(32'h1000_0000, 1'b0);
        send_value(32'd2, 1'b0);
        send_value(32'd1, 1'b0);

        // Zero tolerance, full cap: exact squares converge, others hit the cap
        set_config(32'd0, 32'd63);
        send_value(32'd9, 1'b0);
        send_value(32'd10, 1'b0);
        send_value(32'h7FFF_FFFF, 1'b0);

        // Hold off the result side while fast words keep coming
        set_config(32'hFFFF_FFFF, 32'd4);
        stall_request = 1'b1;
        repeat (16) begin
            if ($urandom_range(0, 1) == 0) send_value($urandom | 32'h8000_0000, 1'b1);
            else send_value($urandom_range(0, 64), 1'b1);
        end

        // Random phases, each under its own settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin tol = 32'hFFFF_FFFF; cap = 63; count = 80; end
                1: begin tol = 32'd0; cap = 63; count = 12; end
                2: begin tol = 32'd1; cap = 1; count = 100; end
                3: begin tol = 32'd65536; cap = 12; count = 70; end
                4: begin tol = $urandom; cap = $urandom_range(1, 20); count = 70; end
                5: begin
                    tol   = $urandom >> $urandom_range(0, 31);
                    cap   = $urandom_range(1, 20);
                    count = 70;
                end
                6: begin tol = $urandom >> 16; cap = 63; count = 25; end
                7: begin
                    tol   = 32'hFFFF_FFFF >> $urandom_range(0, 8);
                    cap   = $urandom_range(1, 40);
                    count = 70;
                end
                default: begin
                    tol   = hsr_pkg::TOL_RESET;
                    cap   = hsr_pkg::ITER_RESET;
                    count = 40;
                end
            endcase
            set_config(tol, cap);
            repeat (count) send_value(pick_value(), 1'b0);
        end

        // Drain, let the block settle, report
        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (board.errors == 0 && board.pending_roots.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/hsr_pkg.sv
hdl/hsr_mul.sv
hdl/hsr_div.sv
hdl/heron_square_root.sv
test/heron_square_root_test.sv
